// ----- rtl/byte_stuffed_packet_framer_defines.svh -----
// Assertion macros shared by the framer RTL.
`ifndef BYTE_STUFFED_PACKET_FRAMER_DEFINES_SVH
`define BYTE_STUFFED_PACKET_FRAMER_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define BSPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle.
`define BSPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSPF_ASSERT(lbl, prop, msg)
`define BSPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/bspf_pkg.sv -----
// Shared types, constants and helpers of the byte-stuffed packet framer.
package bspf_pkg;

  localparam int unsigned MAX_FRAME_DEF = 32;
  localparam int unsigned NUM_SLOTS     = 4;
  localparam int unsigned CNT_W         = $clog2(NUM_SLOTS + 1);
  localparam int unsigned PADDR_W       = 4;
  localparam int unsigned PDATA_W       = 32;

  localparam logic [7:0] START_CODE_RST  = 8'd36;
  localparam logic [7:0] END_CODE_RST    = 8'd13;
  localparam logic [7:0] ESCAPE_CODE_RST = 8'd16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_END    = 2'd1,
    REG_ESCAPE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] command;
    logic [7:0] data_length;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic       abort;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
  } cfg_t;

  typedef struct packed {
    out_item_t [NUM_SLOTS-1:0] slot;
    logic [CNT_W-1:0]          count;
  } burst_t;

  function automatic out_item_t mk_item(logic [7:0] b, logic eof, logic abrt);
    out_item_t w;
    w.out_byte     = b;
    w.end_of_frame = eof;
    w.abort        = abrt;
    w.last         = 1'b0;
    return w;
  endfunction

endpackage

// ----- rtl/bspf_regs.sv -----
// APB configuration registers holding the start, end and escape codes.
module bspf_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bspf_pkg::PADDR_W-1:0] paddr,
  input  logic [bspf_pkg::PDATA_W-1:0] pwdata,
  output logic [bspf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output bspf_pkg::cfg_t               cfg
);

  bspf_pkg::cfg_t     cfg_r, cfg_nxt;
  bspf_pkg::reg_idx_t idx;
  logic               wr_en;
  logic [7:0]         rd_byte;

  assign idx    = bspf_pkg::reg_idx_t'(paddr[bspf_pkg::PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        bspf_pkg::REG_START:  cfg_nxt.start_code  = pwdata[7:0];
        bspf_pkg::REG_END:    cfg_nxt.end_code    = pwdata[7:0];
        bspf_pkg::REG_ESCAPE: cfg_nxt.escape_code = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bspf_pkg::REG_START:  rd_byte = cfg_r.start_code;
      bspf_pkg::REG_END:    rd_byte = cfg_r.end_code;
      bspf_pkg::REG_ESCAPE: rd_byte = cfg_r.escape_code;
      default:              rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(bspf_pkg::PDATA_W-8){1'b0}}, rd_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= bspf_pkg::START_CODE_RST;
      cfg_r.end_code    <= bspf_pkg::END_CODE_RST;
      cfg_r.escape_code <= bspf_pkg::ESCAPE_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/bspf_frame.sv -----
// Input register, framing state and per-word burst builder.
`include "byte_stuffed_packet_framer_defines.svh"
module bspf_frame #(
  parameter int unsigned MAX_FRAME = bspf_pkg::MAX_FRAME_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bspf_pkg::in_item_t in_data,
  input  bspf_pkg::cfg_t     cfg,
  input  logic               emit_ready,
  output logic               burst_valid,
  output bspf_pkg::burst_t   burst
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME + 1);

  bspf_pkg::in_item_t item_r;
  logic               item_valid_r, item_valid_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   remain_r, remain_nxt;
  logic               in_packet_r, in_packet_nxt;
  logic               dropping_r, dropping_nxt;

  logic               take;
  logic               accept;
  logic               too_long;
  logic               fin;
  logic               esc;
  logic [1:0]         need;
  logic               overflow;
  logic [7:0]         db;

  assign db       = item_r.data_byte;
  assign too_long = {1'b0, item_r.data_length} > 9'(MAX_FRAME);
  assign fin      = remain_r <= POS_W'(1);
  assign esc      = (db == cfg.start_code) || (db == cfg.end_code) || (db == cfg.escape_code);
  assign need     = (esc ? 2'd2 : 2'd1) + {1'b0, fin};
  assign overflow = ({2'b00, pos_r} + (POS_W+2)'(need)) > (POS_W+2)'(MAX_FRAME);

  always_comb begin
    burst        = '0;
    pos_nxt      = pos_r;
    remain_nxt   = remain_r;
    in_packet_nxt = in_packet_r;
    dropping_nxt = dropping_r;
    if (item_valid_r) begin
      case (item_r.operation)
        bspf_pkg::OP_START: begin
          if (!in_packet_r) begin
            if (too_long) begin
              burst.slot[0] = bspf_pkg::mk_item(8'd0, 1'b0, 1'b1);
              burst.count   = bspf_pkg::CNT_W'(1);
            end else begin
              burst.slot[0] = bspf_pkg::mk_item(cfg.start_code, 1'b0, 1'b0);
              burst.slot[1] = bspf_pkg::mk_item(item_r.command, 1'b0, 1'b0);
              burst.slot[2] = bspf_pkg::mk_item(item_r.data_length, 1'b0, 1'b0);
              if (item_r.data_length == 8'd0) begin
                burst.slot[3] = bspf_pkg::mk_item(cfg.end_code, 1'b1, 1'b0);
                burst.count   = bspf_pkg::CNT_W'(4);
                pos_nxt       = POS_W'(4);
              end else begin
                burst.count   = bspf_pkg::CNT_W'(3);
                pos_nxt       = POS_W'(3);
                in_packet_nxt = 1'b1;
                dropping_nxt  = 1'b0;
                remain_nxt    = POS_W'(item_r.data_length);
              end
            end
          end
        end
        bspf_pkg::OP_DATA: begin
          if (in_packet_r) begin
            if (!dropping_r) begin
              if (overflow) begin
                burst.slot[0] = bspf_pkg::mk_item(8'd0, 1'b0, 1'b1);
                burst.count   = bspf_pkg::CNT_W'(1);
                dropping_nxt  = 1'b1;
              end else begin
                if (esc) begin
                  burst.slot[0] = bspf_pkg::mk_item(cfg.escape_code, 1'b0, 1'b0);
                  burst.slot[1] = bspf_pkg::mk_item(db, 1'b0, 1'b0);
                  burst.slot[2] = bspf_pkg::mk_item(cfg.end_code, 1'b1, 1'b0);
                end else begin
                  burst.slot[0] = bspf_pkg::mk_item(db, 1'b0, 1'b0);
                  burst.slot[1] = bspf_pkg::mk_item(cfg.end_code, 1'b1, 1'b0);
                end
                burst.count = bspf_pkg::CNT_W'(need);
                pos_nxt     = pos_r + POS_W'(need);
              end
            end
            if (fin) begin
              in_packet_nxt = 1'b0;
              dropping_nxt  = 1'b0;
              remain_nxt    = '0;
            end else begin
              remain_nxt = remain_r - POS_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
    // flag the tail of the burst
    for (int i = 0; i < bspf_pkg::NUM_SLOTS; i++) begin
      if (burst.count == bspf_pkg::CNT_W'(i + 1)) begin
        burst.slot[i].last = 1'b1;
      end
    end
  end

  assign burst_valid    = item_valid_r && (burst.count != '0);
  assign take           = item_valid_r && ((burst.count == '0) || emit_ready);
  assign in_ready       = !item_valid_r || take;
  assign accept         = in_valid && in_ready;
  assign item_valid_nxt = accept ? 1'b1 : (take ? 1'b0 : item_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      pos_r        <= '0;
      remain_r     <= '0;
      in_packet_r  <= 1'b0;
      dropping_r   <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      if (take) begin
        pos_r       <= pos_nxt;
        remain_r    <= remain_nxt;
        in_packet_r <= in_packet_nxt;
        dropping_r  <= dropping_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  `BSPF_ASSERT(a_drop_in_pkt, dropping_r |-> in_packet_r, "dropping outside a packet")
  `BSPF_ASSERT(a_pos_bound, pos_r <= POS_W'(MAX_FRAME), "frame position past limit")
  `BSPF_ASSERT_NEXT(a_fin_close, take && item_r.operation == bspf_pkg::OP_DATA && in_packet_r && fin, !in_packet_r && !dropping_r, "final data word left packet open")

endmodule

// ----- rtl/bspf_emit.sv -----
// Output burst register that hands results out one word per cycle while out_ready is high.
`include "byte_stuffed_packet_framer_defines.svh"
module bspf_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                burst_valid,
  input  bspf_pkg::burst_t    burst,
  output logic                emit_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bspf_pkg::out_item_t out_data
);

  bspf_pkg::out_item_t [bspf_pkg::NUM_SLOTS-1:0] slot_r, slot_nxt;
  logic [bspf_pkg::CNT_W-1:0]                    count_r, count_nxt;

  assign out_valid  = count_r != '0;
  assign out_data   = slot_r[0];
  assign emit_ready = (count_r == '0) || ((count_r == bspf_pkg::CNT_W'(1)) && out_ready);

  always_comb begin
    slot_nxt  = slot_r;
    count_nxt = count_r;
    if (burst_valid && emit_ready) begin
      slot_nxt  = burst.slot;
      count_nxt = burst.count;
    end else if (out_valid && out_ready) begin
      // advance the queue by one word
      for (int i = 0; i < bspf_pkg::NUM_SLOTS - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      slot_nxt[bspf_pkg::NUM_SLOTS-1] = '0;
      count_nxt = count_r - bspf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  `BSPF_ASSERT(a_last_tail, (count_r == bspf_pkg::CNT_W'(1)) |-> slot_r[0].last, "tail word lacks last")
  `BSPF_ASSERT(a_no_early_last, (count_r > bspf_pkg::CNT_W'(1)) |-> !slot_r[0].last, "last set before tail")
  `BSPF_ASSERT(a_abort_alone, (out_valid && slot_r[0].abort) |-> (count_r == bspf_pkg::CNT_W'(1)), "abort shares a burst")

endmodule

// ----- rtl/byte_stuffed_packet_framer.sv -----
// Top level of the byte-stuffed packet framer.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one word per packet start
//   (operation = start, with command and data_length) followed by data_length
//   data words (operation = data, one data_byte each).
//   Output channel (out_valid/out_ready/out_data) delivers framed bytes one
//   word per cycle: start code, command, length, stuffed data, end code.
//   A data byte equal to any code goes out behind the escape code. last
//   marks the final word produced by one input word; abort means the frame
//   blew the size limit and downstream must drop what it has of it.
//   An input word is registered in the input register, and its burst in the
//   output burst register once the previous burst drains, before its first
//   output word is valid. Output runs one word per cycle while out_ready is
//   high; an input word makes one to four results over the single-word
//   output port. Words that make no result retire without waiting on it.
//   The input register can take a word while the output burst drains.
//   Stall: with out_ready low the burst holds, then the input register
//   fills and in_ready drops; nothing is lost.
//   Reset: codes return to 36/13/16, framer goes idle, queues empty.
//   The user must write codes over APB while the block is idle; unchecked.
module byte_stuffed_packet_framer #(
  parameter int unsigned MAX_FRAME = bspf_pkg::MAX_FRAME_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bspf_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bspf_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bspf_pkg::PADDR_W-1:0] paddr,
  input  logic [bspf_pkg::PDATA_W-1:0] pwdata,
  output logic [bspf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  bspf_pkg::cfg_t   cfg;
  bspf_pkg::burst_t burst;
  logic             burst_valid;
  logic             emit_ready;

  // hold the code registers
  bspf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // register the input word, track the frame and build its result burst
  bspf_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg         (cfg),
    .emit_ready  (emit_ready),
    .burst_valid (burst_valid),
    .burst       (burst)
  );

  // drain the burst one word per cycle while out_ready is high
  bspf_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst_valid (burst_valid),
    .burst       (burst),
    .emit_ready  (emit_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the byte-stuffed packet framer: directed and random packets.
module tb_top;

  // The frame limit matches the default parameter of the block.
  localparam int unsigned FRAME_LIMIT   = bspf_pkg::MAX_FRAME_DEF;
  // Hold this long after the last result before touching the code registers,
  // so that words which make no result have retired.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Cycles without any handshake before the run is declared hung. This is far
  // above the longest sender gap plus the longest receiver stall.
  localparam int unsigned IDLE_LIMIT    = 2000;

  // Framer predictor and queue of expected framed bytes.
  class framer_scoreboard;
    logic [7:0]           start_code;
    logic [7:0]           end_code;
    logic [7:0]           escape_code;
    int unsigned          frame_pos;
    int unsigned          bytes_left;
    bit                   in_pkt;
    bit                   dropping;
    bspf_pkg::out_item_t  expected_q[$];
    int unsigned          errors;

    function new();
      start_code  = bspf_pkg::START_CODE_RST;
      end_code    = bspf_pkg::END_CODE_RST;
      escape_code = bspf_pkg::ESCAPE_CODE_RST;
      frame_pos   = 0;
      bytes_left  = 0;
      in_pkt      = 1'b0;
      dropping    = 1'b0;
      errors      = 0;
    endfunction

    function void set_code(bspf_pkg::reg_idx_t idx, logic [7:0] value);
      case (idx)
        bspf_pkg::REG_START:  start_code  = value;
        bspf_pkg::REG_END:    end_code    = value;
        bspf_pkg::REG_ESCAPE: escape_code = value;
        default: ;
      endcase
    endfunction

    function bit is_code(logic [7:0] b);
      return (b == start_code) || (b == end_code) || (b == escape_code);
    endfunction

    function bspf_pkg::out_item_t framed(logic [7:0] b, bit eof, bit abrt);
      bspf_pkg::out_item_t w;
      w.out_byte     = b;
      w.end_of_frame = eof;
      w.abort        = abrt;
      w.last         = 1'b0;
      return w;
    endfunction

    // Predict the framed bytes of one accepted word; return 0 if the block ignores it.
    function bit note_input(bspf_pkg::in_item_t item);
      bspf_pkg::out_item_t burst[$];
      bit                  fin;
      bit                  esc;
      int unsigned         need;
      if (item.operation == bspf_pkg::OP_START) begin
        // A start inside an open packet is dropped silently.
        if (in_pkt) return 1'b0;
        if (32'(item.data_length) > FRAME_LIMIT) begin
          burst.push_back(framed(8'h00, 1'b0, 1'b1));
        end else begin
          burst.push_back(framed(start_code, 1'b0, 1'b0));
          burst.push_back(framed(item.command, 1'b0, 1'b0));
          burst.push_back(framed(item.data_length, 1'b0, 1'b0));
          frame_pos = 3;
          if (item.data_length == 8'd0) begin
            burst.push_back(framed(end_code, 1'b1, 1'b0));
            frame_pos = 4;
          end else begin
            in_pkt     = 1'b1;
            dropping   = 1'b0;
            bytes_left = 32'(item.data_length);
          end
        end
      end else begin
        // Data outside a packet is dropped silently.
        if (!in_pkt) return 1'b0;
        fin = (bytes_left <= 1);
        if (!dropping) begin
          esc  = is_code(item.data_byte);
          need = (esc ? 2 : 1) + (fin ? 1 : 0);
          // Reserve room for the escape, the byte and the closing end code.
          if (frame_pos + need > FRAME_LIMIT) begin
            burst.push_back(framed(8'h00, 1'b0, 1'b1));
            dropping = 1'b1;
          end else begin
            if (esc) burst.push_back(framed(escape_code, 1'b0, 1'b0));
            burst.push_back(framed(item.data_byte, 1'b0, 1'b0));
            if (fin) burst.push_back(framed(end_code, 1'b1, 1'b0));
            frame_pos += need;
          end
        end
        if (fin) begin
          in_pkt     = 1'b0;
          dropping   = 1'b0;
          bytes_left = 0;
        end else begin
          bytes_left--;
        end
      end
      if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected_q.push_back(burst[i]);
      return 1'b1;
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(bspf_pkg::out_item_t got);
      bspf_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected word: out_byte 0x%0h end_of_frame %0b abort %0b last %0b",
               got.out_byte, got.end_of_frame, got.abort, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      // out_byte carries no meaning on an abort word.
      if (!want.abort) compare("out_byte", want.out_byte, got.out_byte);
      compare("end_of_frame", 8'(want.end_of_frame), 8'(got.end_of_frame));
      compare("abort", 8'(want.abort), 8'(got.abort));
      compare("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  bspf_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  bspf_pkg::out_item_t            out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bspf_pkg::PADDR_W-1:0]   paddr;
  logic [bspf_pkg::PDATA_W-1:0]   pwdata;
  logic [bspf_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  framer_scoreboard sb = new();
  int unsigned      taken_items = 0;
  bit               tx_idle_en = 1'b1;
  bit               rx_idle_en = 1'b1;
  int unsigned      idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_stuffed_packet_framer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Gap length: mostly short, now and then medium, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Payload byte: plain avoids every code, otherwise pick a code pct percent of the time, else any byte.
  function automatic logic [7:0] payload_byte(int unsigned pct, bit plain);
    logic [7:0] b;
    if (plain) begin
      do b = 8'($urandom_range(0, 255)); while (sb.is_code(b));
      return b;
    end
    if ($urandom_range(0, 99) < pct) begin
      case ($urandom_range(0, 2))
        0:       return sb.start_code;
        1:       return sb.end_code;
        default: return sb.escape_code;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Unused fields get random values so that every bit toggles.
  function automatic bspf_pkg::in_item_t start_word(logic [7:0] cmd, logic [7:0] len);
    bspf_pkg::in_item_t w;
    w.operation   = bspf_pkg::OP_START;
    w.command     = cmd;
    w.data_length = len;
    w.data_byte   = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic bspf_pkg::in_item_t data_word(logic [7:0] b);
    bspf_pkg::in_item_t w;
    w.operation   = bspf_pkg::OP_DATA;
    w.command     = 8'($urandom_range(0, 255));
    w.data_length = 8'($urandom_range(0, 255));
    w.data_byte   = b;
    return w;
  endfunction

  // Offer one word: optional gap, then hold valid and payload until taken.
  task automatic send_word(input bspf_pkg::in_item_t item);
    int unsigned gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 99) < 30) gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    void'(sb.note_input(item));
    taken_items++;
  endtask

  task automatic send_packet(input logic [7:0] len, input int unsigned pct, input bit plain);
    send_word(start_word(8'($urandom_range(0, 255)), len));
    for (int unsigned i = 0; i < 32'(len); i++) begin
      send_word(data_word(payload_byte(pct, plain)));
    end
  endtask

  // Close any open packet, drop valid, drain every result and let the block settle.
  task automatic close_phase();
    while (sb.in_pkt) send_word(data_word(8'($urandom_range(0, 255))));
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of one code register, then read it back.
  task automatic write_code(input bspf_pkg::reg_idx_t idx, input logic [7:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {{(bspf_pkg::PDATA_W-8){1'b0}}, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.compare(idx.name(), value, prdata[7:0]);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    sb.set_code(idx, value);
  endtask

  task automatic program_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
    write_code(bspf_pkg::REG_START, s);
    write_code(bspf_pkg::REG_END, e);
    write_code(bspf_pkg::REG_ESCAPE, x);
  endtask

  // Edge cases under the reset codes: empty packet, oversize lengths, stray
  // words, every code in the payload, and an escape of the escape code.
  task automatic run_directed();
    send_word(start_word(8'hFF, 8'd0));
    send_word(start_word(8'h00, 8'd255));
    send_word(start_word(8'h81, 8'd33));
    send_word(data_word(8'h55));
    send_word(start_word(8'h5A, 8'd4));
    send_word(data_word(sb.start_code));
    send_word(start_word(8'h11, 8'd2));
    send_word(data_word(sb.end_code));
    send_word(data_word(sb.escape_code));
    send_word(data_word(8'h00));
    send_word(start_word(8'h3C, 8'd1));
    send_word(data_word(8'hFF));
    send_word(start_word(8'hA5, 8'd2));
    send_word(data_word(sb.escape_code));
    send_word(data_word(sb.escape_code));
  endtask

  // Mostly well-formed packets; long code-heavy ones to force overflow,
  // plain ones near the limit to hit the exact fit, plus oversize starts and noise.
  task automatic run_random(input int unsigned target);
    int unsigned        goal;
    int unsigned        r;
    bspf_pkg::in_item_t noise;
    goal = taken_items + target;
    while (taken_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_packet(8'($urandom_range(0, 10)), 25, 1'b0);
      end else if (r < 65) begin
        send_packet(8'($urandom_range(14, 32)), 45, 1'b0);
      end else if (r < 75) begin
        send_packet(8'($urandom_range(27, 32)), 0, 1'b1);
      end else if (r < 85) begin
        send_word(start_word(8'($urandom_range(0, 255)), 8'($urandom_range(33, 255))));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          noise.operation   = 1'($urandom_range(0, 1));
          noise.command     = 8'($urandom_range(0, 255));
          noise.data_length = 8'($urandom_range(0, 255));
          noise.data_byte   = 8'($urandom_range(0, 255));
          send_word(noise);
        end
      end
    end
    close_phase();
  endtask

  // Receiver: random stalls while enabled, otherwise always ready.
  initial begin
    int unsigned hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (rx_idle_en && $urandom_range(0, 99) < 25) hold = pick_gap();
      end
    end
  end

  // Check every word taken on the result side.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: end the run when no handshake happens for too long.
  initial begin
    do @(posedge clk); while (rst_n !== 1'b1);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n   = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    close_phase();

    // Extremes of the code values, no idling on either side.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    program_codes(8'h00, 8'hFF, 8'h80);
    run_random(42);

    // End and escape share a value; both sides idle.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    program_codes(8'hFF, 8'h00, 8'h00);
    run_random(42);

    // All three codes equal; sender gaps only.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    program_codes(8'hAA, 8'hAA, 8'hAA);
    run_random(42);

    // Random codes; receiver stalls only.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    program_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    run_random(42);

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bspf_pkg.sv
rtl/bspf_regs.sv
rtl/bspf_frame.sv
rtl/bspf_emit.sv
rtl/byte_stuffed_packet_framer.sv
sim/tb_top.sv
